// ----- design/nosc_pkg.sv -----
// Shared types, constants and the sigmoid table of the oscillator step.
// Depends on nothing; every other file but nosc_in_if imports it.
package nosc_pkg;

  localparam int WORD_W     = 24;  // Q8.16 activities, rates, gains
  localparam int FRAC_W     = 16;
  localparam int ACT_FRAC   = 16;  // activations in Q1.16
  localparam int ACT_W      = ACT_FRAC + 1;
  localparam int STEP_W     = 16;
  localparam int SLOPE_W    = 20;
  localparam int SLOPE_FRAC = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int LANES      = 2;   // lane 0 is u, lane 1 is v

  localparam int MUL_W  = WORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam int SIG_ADDR_W = $clog2(SIG_DEPTH + 1);
  localparam int SIG_SH     = FRAC_W + SLOPE_FRAC + 4;
  localparam int SIG_POS_W  = SIG_SH + SIG_IDX_W;
  localparam int FR_W       = 16;

  localparam logic signed [PROD_W-1:0] SIG_HALF =
      PROD_W'(8) <<< (FRAC_W + SLOPE_FRAC);
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(1) <<< (ACT_FRAC - 1);
  localparam logic signed [PROD_W-1:0] WORD_MAX_X = (PROD_W'(1) <<< (WORD_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] WORD_MIN_X = -(PROD_W'(1) <<< (WORD_W - 1));

  typedef logic [ACT_W-1:0] act_t;
  typedef act_t sig_rom_t [SIG_DEPTH+1];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_UU   = 3'd0,
    REG_GAIN_UV   = 3'd1,
    REG_GAIN_VU   = 3'd2,
    REG_GAIN_VV   = 3'd3,
    REG_BIAS_U    = 3'd4,
    REG_BIAS_V    = 3'd5,
    REG_STEP_SIZE = 3'd6,
    REG_SLOPE     = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_SIG,
    OP_SPLIT,
    OP_INTERP,
    OP_SCALE,
    OP_UPDATE
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_SIG,
    ST_SPLIT,
    ST_INTERP,
    ST_SCALE,
    ST_UPDATE
  } ctrl_state_e;

  // Round to nearest, ties up, dropping ACT_FRAC bits.
  function automatic logic signed [PROD_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] x);
    return (x + RND_HALF) >>> ACT_FRAC;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    if (x > WORD_MAX_X) begin
      return WORD_W'(WORD_MAX_X);
    end else if (x < WORD_MIN_X) begin
      return WORD_W'(WORD_MIN_X);
    end
    return WORD_W'(x);
  endfunction

  // unsigned shift-and-subtract quotient, table build only
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-z), Q30 in and out, series then repeated squaring
  function automatic longint unsigned exp_neg_q30(input longint unsigned z);
    longint unsigned t;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    t    = z >> 5;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int k = 1; k <= 13; k++) begin
      term = div_u64((term * t) >> 30, 64'(k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    for (int n = 0; n < 5; n++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t        rom;
    longint unsigned pos;
    longint unsigned z;
    longint unsigned den;
    longint unsigned l;
    longint unsigned mid;
    mid = 64'd16 << 30;
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      pos = ((64'(i) * 64'd32) << 30) >> SIG_IDX_W;
      z   = (pos >= mid) ? pos - mid : mid - pos;
      den = (64'd1 << 30) + exp_neg_q30(z);
      l   = div_u64((64'd1 << 46) + (den >> 1), den);
      rom[i] = (pos >= mid) ? ACT_W'(l) : ACT_W'((64'd1 << ACT_FRAC) - l);
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ----- design/nosc_in_if.sv -----
// Tick channel into the oscillator: valid/ready plus the advance bit.
// Depends on nothing.
interface nosc_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

// ----- design/nosc_out_if.sv -----
// Result channel out of the oscillator: valid/ready plus u, v and rates.
// Depends on nosc_pkg for the word width.
interface nosc_out_if import nosc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] u_value;
  logic signed [WORD_W-1:0] v_value;
  logic signed [WORD_W-1:0] u_rate;
  logic signed [WORD_W-1:0] v_rate;

  modport source (output valid, output u_value, output v_value, output u_rate,
                  output v_rate, input ready);
  modport sink   (input valid, input u_value, input v_value, input u_rate,
                  input v_rate, output ready);
endinterface

// ----- design/nosc_ctrl.sv -----
// Step sequencer: walks one tick through the datapath operations and owns
// the result word's valid flag. Depends on nosc_pkg.
module nosc_ctrl import nosc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_advance_i,
  output logic   in_ready_o,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output dp_op_e op_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        commit;

  assign out_free = ~out_valid_q | out_ready_i;
  assign commit   = (state_q == ST_UPDATE) & out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_advance_i) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A:   state_d = ST_MUL_B;
      ST_MUL_B:   state_d = ST_MUL_SIG;
      ST_MUL_SIG: state_d = ST_SPLIT;
      ST_SPLIT:   state_d = ST_INTERP;
      ST_INTERP:  state_d = ST_SCALE;
      ST_SCALE:   state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_MUL_A:   op_o = OP_MUL_A;
      ST_MUL_B:   op_o = OP_MUL_B;
      ST_MUL_SIG: op_o = OP_MUL_SIG;
      ST_SPLIT:   op_o = OP_SPLIT;
      ST_INTERP:  op_o = OP_INTERP;
      ST_SCALE:   op_o = OP_SCALE;
      ST_UPDATE:  op_o = commit ? OP_UPDATE : OP_NOP;
      default:    op_o = OP_NOP;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/nosc_datapath.sv -----
// Two-lane datapath: config registers, u/v state, one multiplier per lane,
// sigmoid lookup with interpolation, and the result word registers.
// Depends on nosc_pkg.
module nosc_datapath import nosc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [WORD_W-1:0]        cfg_data_i,
  input  dp_op_e                   op_i,
  output logic signed [WORD_W-1:0] u_value_o,
  output logic signed [WORD_W-1:0] v_value_o,
  output logic signed [WORD_W-1:0] u_rate_o,
  output logic signed [WORD_W-1:0] v_rate_o
);

  logic signed [WORD_W-1:0] gain_uu_q, gain_uv_q, gain_vu_q, gain_vv_q;
  logic signed [WORD_W-1:0] bias_u_q, bias_v_q;
  logic [STEP_W-1:0]        step_q;
  logic [SLOPE_W-1:0]       slope_q;

  logic signed [WORD_W-1:0] lvl_q  [LANES];
  logic signed [WORD_W-1:0] lvl_d  [LANES];
  act_t                     act_q  [LANES];
  act_t                     act_d  [LANES];
  logic signed [PROD_W-1:0] acc_q  [LANES];
  logic signed [PROD_W-1:0] acc_d  [LANES];
  logic signed [PROD_W-1:0] p_q    [LANES];
  logic signed [WORD_W-1:0] rate_q [LANES];
  logic signed [WORD_W-1:0] rate_d [LANES];
  logic [SIG_ADDR_W-1:0]    idx_q  [LANES];
  logic [SIG_ADDR_W-1:0]    idx_d  [LANES];
  logic [FR_W-1:0]          fr_q   [LANES];
  logic [FR_W-1:0]          fr_d   [LANES];
  logic                     top_q  [LANES];
  logic                     top_d  [LANES];
  act_t                     lo_q   [LANES];
  act_t                     rom_lo [LANES];
  act_t                     rom_hi [LANES];
  act_t                     diff   [LANES];
  logic signed [MUL_W-1:0]  mul_a  [LANES];
  logic signed [MUL_W-1:0]  mul_b  [LANES];
  logic signed [PROD_W-1:0] prod   [LANES];
  logic signed [WORD_W-1:0] gain_a [LANES];
  logic signed [WORD_W-1:0] gain_b [LANES];
  logic signed [WORD_W-1:0] bias   [LANES];
  logic [SIG_SH-1:0]        off    [LANES];
  logic [SIG_POS_W-1:0]     pos    [LANES];
  logic                     below  [LANES];
  logic                     mul_en;

  assign gain_a[0] = gain_uu_q;
  assign gain_b[0] = gain_vu_q;
  assign bias[0]   = bias_u_q;
  assign gain_a[1] = gain_uv_q;
  assign gain_b[1] = gain_vv_q;
  assign bias[1]   = bias_v_q;

  assign mul_en = (op_i == OP_MUL_A) || (op_i == OP_MUL_B) || (op_i == OP_MUL_SIG) ||
                  (op_i == OP_INTERP) || (op_i == OP_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_uu_q <= 24'sd655360;
      gain_uv_q <= 24'sd327680;
      gain_vu_q <= 24'sd655360;
      gain_vv_q <= '0;
      bias_u_q  <= '0;
      bias_v_q  <= -24'sd163840;
      step_q    <= 16'd655;
      slope_q   <= 20'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_UU:   gain_uu_q <= cfg_data_i;
        REG_GAIN_UV:   gain_uv_q <= cfg_data_i;
        REG_GAIN_VU:   gain_vu_q <= cfg_data_i;
        REG_GAIN_VV:   gain_vv_q <= cfg_data_i;
        REG_BIAS_U:    bias_u_q  <= cfg_data_i;
        REG_BIAS_V:    bias_v_q  <= cfg_data_i;
        REG_STEP_SIZE: step_q    <= cfg_data_i[STEP_W-1:0];
        REG_SLOPE:     slope_q   <= cfg_data_i[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rom_lo[l] = top_q[l] ? SIG_ROM[SIG_DEPTH] : SIG_ROM[idx_q[l]];
      rom_hi[l] = top_q[l] ? SIG_ROM[SIG_DEPTH] : SIG_ROM[SIG_ADDR_W'(idx_q[l] + 1'b1)];
      diff[l]   = rom_hi[l] - rom_lo[l];

      mul_a[l] = '0;
      mul_b[l] = '0;
      unique case (op_i)
        OP_MUL_A: begin
          mul_a[l] = MUL_W'(gain_a[l]);
          mul_b[l] = MUL_W'(act_q[0]);
        end
        OP_MUL_B: begin
          mul_a[l] = MUL_W'(gain_b[l]);
          mul_b[l] = MUL_W'(act_q[1]);
        end
        OP_MUL_SIG: begin
          mul_a[l] = MUL_W'(lvl_q[l]);
          mul_b[l] = MUL_W'(slope_q);
        end
        OP_INTERP: begin
          mul_a[l] = MUL_W'(diff[l]);
          mul_b[l] = MUL_W'(fr_q[l]);
        end
        OP_SCALE: begin
          mul_a[l] = MUL_W'(rate_q[l]);
          mul_b[l] = MUL_W'(step_q);
        end
        default: ;
      endcase
      prod[l] = mul_a[l] * mul_b[l];

      // sigmoid argument split into table index and fraction
      off[l]   = SIG_SH'(p_q[l] + SIG_HALF);
      pos[l]   = SIG_POS_W'(off[l]) * SIG_POS_W'(SIG_DEPTH);
      below[l] = p_q[l] < -SIG_HALF;
      top_d[l] = p_q[l] >= SIG_HALF;
      idx_d[l] = below[l] ? '0 : SIG_ADDR_W'(pos[l][SIG_POS_W-1:SIG_SH]);
      fr_d[l]  = below[l] ? '0 : pos[l][SIG_SH-1 -: FR_W];

      rate_d[l] = sat_word(rnd_frac(acc_q[l]));

      acc_d[l] = acc_q[l];
      unique case (op_i)
        OP_MUL_A:   acc_d[l] = (PROD_W'(bias[l]) - PROD_W'(lvl_q[l])) <<< ACT_FRAC;
        OP_MUL_B:   acc_d[l] = acc_q[l] + p_q[l];
        OP_MUL_SIG: acc_d[l] = acc_q[l] - p_q[l];
        default: ;
      endcase

      act_d[l] = lo_q[l] + p_q[l][ACT_FRAC +: ACT_W];
      lvl_d[l] = sat_word(PROD_W'(lvl_q[l]) + rnd_frac(p_q[l]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      acc_q[l] <= acc_d[l];
      if (mul_en) begin
        p_q[l] <= prod[l];
      end
      if (op_i == OP_SPLIT) begin
        rate_q[l] <= rate_d[l];
        idx_q[l]  <= idx_d[l];
        fr_q[l]   <= fr_d[l];
        top_q[l]  <= top_d[l];
      end
      if (op_i == OP_INTERP) begin
        lo_q[l] <= rom_lo[l];
      end
    end
    if (op_i == OP_UPDATE) begin
      u_value_o <= lvl_d[0];
      v_value_o <= lvl_d[1];
      u_rate_o  <= rate_q[0];
      v_rate_o  <= rate_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) begin
        lvl_q[l] <= '0;
        act_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LANES; l++) begin
        if (op_i == OP_SCALE) begin
          act_q[l] <= act_d[l];
        end
        if (op_i == OP_UPDATE) begin
          lvl_q[l] <= lvl_d[l];
        end
      end
    end
  end

endmodule

// ----- design/neural_oscillator_euler_step.sv -----
// Top level of the excitatory/inhibitory oscillator, one Euler step per advancing tick.
// Depends on nosc_pkg, nosc_in_if, nosc_out_if, nosc_ctrl, nosc_datapath.
// Usage:
//   in_i carries tick words; a word with advance set runs one step, a word
//   with advance clear is taken and dropped with no result.
//   out_o carries one word per step: new u and v, and the rates of the step.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; unknown indexes do not occur in a 3-bit index.
// Timing:
//   A step walks the sequencer states MUL_A, MUL_B, MUL_SIG, SPLIT, INTERP,
//   SCALE and UPDATE in turn; five states use the multiplier of each neuron
//   lane (two gain products, the sigmoid argument, interpolation, the step
//   scaling). The next tick is taken the cycle after the result is registered,
//   so no new tick is taken while a step is still in flight.
// Reset:
//   u, v and both activations clear; configuration takes its default values.
// Stall:
//   A finished word waits in the output register; the next step runs
//   meanwhile and holds in its last state until that word is taken.
module neural_oscillator_euler_step import nosc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nosc_in_if.sink              in_i,
  nosc_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  dp_op_e op;

  nosc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_advance_i (in_i.advance),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .op_o         (op)
  );

  nosc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (op),
    .u_value_o  (out_o.u_value),
    .v_value_o  (out_o.v_value),
    .u_rate_o   (out_o.u_rate),
    .v_rate_o   (out_o.v_rate)
  );

endmodule

// ----- tb/sv/neural_oscillator_euler_step_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for neural_oscillator_euler_step: directed rows, then random ticks.
// An in-bench Euler-step model predicts all but the typed first word; both sides stall.
// Depends on nosc_pkg, nosc_in_if, nosc_out_if and the top level.
module neural_oscillator_euler_step_tb;
  import nosc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_STEPS  = 250;

  localparam logic [23:0] WORD_HI = 24'h7FFFFF;
  localparam logic [23:0] WORD_LO = 24'h800000;

  typedef struct packed {
    logic signed [WORD_W-1:0] u_value;
    logic signed [WORD_W-1:0] v_value;
    logic signed [WORD_W-1:0] u_rate;
    logic signed [WORD_W-1:0] v_rate;
  } osc_word_t;

  typedef struct packed {
    bit          is_cfg;
    cfg_reg_e    reg_idx;
    logic [23:0] data;
    bit          adv;
    bit          typed;
    osc_word_t   want;
  } stim_row_t;

  localparam osc_word_t NO_WORD    = '0;
  // first step from reset: only the v bias drives anything
  localparam osc_word_t FIRST_WORD = '{u_value: 24'sd0, v_value: -24'sd1637,
                                       u_rate: 24'sd0, v_rate: -24'sd163840};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  nosc_in_if  tick_ch ();
  nosc_out_if step_ch ();

  neural_oscillator_euler_step uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (step_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // model state and configuration
  longint    logistic_lut [0:SIG_DEPTH];
  longint    u_now, v_now, u_fire, v_fire;
  longint    a_uu, a_uv, a_vu, a_vv, drive_u, drive_v, tau, mu;
  osc_word_t awaited_steps [$];
  osc_word_t head_word;
  int        mismatch_count;
  int        cycle_count;
  int        in_gap_pct;
  int        ready_gap_pct;
  int        stall_left;
  bit        ticks_since_cfg;
  int        steps_sent;

  stim_row_t directed_rows [0:37] = '{
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b1, FIRST_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b1, REG_SLOPE,     24'h0FFFFF, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_STEP_SIZE, 24'h00FFFF, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_UU,   WORD_HI,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_BIAS_U,    WORD_HI,    1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_UU,   WORD_LO,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_VU,   WORD_HI,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_UV,   WORD_LO,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_VV,   WORD_LO,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_BIAS_U,    WORD_LO,    1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_BIAS_V,    WORD_LO,    1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b1, REG_SLOPE,     24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_STEP_SIZE, 24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_UU,   24'h0A0000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_UV,   24'h050000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_VU,   24'h0A0000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_GAIN_VV,   24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_BIAS_U,    24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_BIAS_V,    24'hFD8000, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_STEP_SIZE, 24'h00028F, 1'b0, 1'b0, NO_WORD},
    '{1'b1, REG_SLOPE,     24'h010000, 1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b0, 1'b0, NO_WORD},
    '{1'b0, REG_GAIN_UU,   24'h000000, 1'b1, 1'b0, NO_WORD}
  };

  int in_pct_of_phase    [0:PHASES-1] = '{0, 25, 10, 50, 0, 30};
  int ready_pct_of_phase [0:PHASES-1] = '{20, 0, 40, 10, 0, 60};

  always #2 clk_i = ~clk_i;

  // logistic table: exp(-z) in Q30 by series and squaring, mirrored below the midpoint
  initial begin : build_lut
    longint unsigned p, z, den, l, term, t, e, mid;
    longint          sum;
    mid = 64'd16 << 30;
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      p    = ((64'(i) * 64'd32) << 30) / 64'(SIG_DEPTH);
      z    = (p >= mid) ? p - mid : mid - p;
      t    = z >> 5;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 13; k++) begin
        term = ((term * t) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = (sum < 0) ? 64'd0 : 64'(sum);
      for (int n = 0; n < 5; n++) begin
        e = (e * e + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + e;
      l   = ((64'd1 << 46) + den / 64'd2) / den;
      logistic_lut[i] = (p >= mid) ? longint'(l) : longint'((64'd1 << 16) - l);
    end
  end

  function automatic longint round_q16(input longint a);
    return (a + longint'(32768)) >>> 16;
  endfunction

  function automatic longint saturate_word(input longint a);
    if (a > longint'(8388607)) begin
      return longint'(8388607);
    end else if (a < -longint'(8388608)) begin
      return -longint'(8388608);
    end
    return a;
  endfunction

  function automatic longint logistic(input longint x);
    longint y, halfw, pos, idx, fr, lo, hi;
    y     = mu * x;
    halfw = longint'(8) <<< 32;
    if (y < -halfw) begin
      return logistic_lut[0];
    end else if (y >= halfw) begin
      return logistic_lut[SIG_DEPTH];
    end
    pos = (y + halfw) * SIG_DEPTH;
    idx = pos >>> 36;
    fr  = (pos - (idx <<< 36)) >>> 20;
    if (idx >= SIG_DEPTH) begin
      idx = SIG_DEPTH - 1;
    end
    lo = logistic_lut[idx];
    hi = logistic_lut[idx + 1];
    return lo + (((hi - lo) * fr) >>> 16);
  endfunction

  function automatic longint drive_rate(input longint lvl, input longint ga, input longint gb,
                                        input longint bias);
    longint acc;
    acc = (bias - lvl) * longint'(65536) + ga * u_fire - gb * v_fire;
    return saturate_word(round_q16(acc));
  endfunction

  function automatic osc_word_t advance_oscillator();
    longint    ur, vr;
    osc_word_t w;
    ur     = drive_rate(u_now, a_uu, a_vu, drive_u);
    vr     = drive_rate(v_now, a_uv, a_vv, drive_v);
    u_fire = logistic(u_now);
    v_fire = logistic(v_now);
    u_now  = saturate_word(u_now + round_q16(tau * ur));
    v_now  = saturate_word(v_now + round_q16(tau * vr));
    w.u_value = u_now[WORD_W-1:0];
    w.v_value = v_now[WORD_W-1:0];
    w.u_rate  = ur[WORD_W-1:0];
    w.v_rate  = vr[WORD_W-1:0];
    return w;
  endfunction

  function automatic int idle_len(input int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [23:0] pick_reg_value(input cfg_reg_e which);
    int r;
    int span;
    r = $urandom_range(0, 99);
    case (which)
      REG_STEP_SIZE: begin
        if (r < 10) return 24'h00FFFF;
        if (r < 15) return 24'h000000;
        if (r < 35) return 24'($urandom_range(0, 65535));
        return 24'($urandom_range(1, 3000));
      end
      REG_SLOPE: begin
        if (r < 10) return 24'h0FFFFF;
        if (r < 15) return 24'h000000;
        if (r < 35) return 24'($urandom_range(0, 1048575));
        return 24'($urandom_range(16384, 262144));
      end
      default: begin
        span = (which == REG_BIAS_U || which == REG_BIAS_V) ? 262144 : 1048576;
        if (r < 8) return WORD_HI;
        if (r < 16) return WORD_LO;
        if (r < 22) return 24'h000000;
        if (r < 50) return 24'($urandom);
        return 24'($urandom_range(0, 2 * span) - span);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    if (mismatch_count < 40) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, $signed(got),
               $signed(want));
    end
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= data;
    case (which)
      REG_GAIN_UU:   a_uu    = longint'($signed(data));
      REG_GAIN_UV:   a_uv    = longint'($signed(data));
      REG_GAIN_VU:   a_vu    = longint'($signed(data));
      REG_GAIN_VV:   a_vv    = longint'($signed(data));
      REG_BIAS_U:    drive_u = longint'($signed(data));
      REG_BIAS_V:    drive_v = longint'($signed(data));
      REG_STEP_SIZE: tau     = longint'(data[STEP_W-1:0]);
      REG_SLOPE:     mu      = longint'(data[SLOPE_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays up across back-to-back words; caller sits on a rising edge
  task automatic send_tick(input bit adv, input bit typed, input osc_word_t want);
    int        gap;
    osc_word_t w;
    gap = idle_len(in_gap_pct);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.advance <= adv;
    do @(posedge clk_i); while (!tick_ch.ready);
    if (adv) begin
      w = advance_oscillator();
      awaited_steps.push_back(typed ? want : w);
    end
  endtask

  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (awaited_steps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      step_ch.ready <= 1'b0;
    end else begin
      stall_left = idle_len(ready_gap_pct);
      step_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && step_ch.valid && step_ch.ready) begin
      if (awaited_steps.size() == 0) begin
        report_mismatch("unexpected word, u_value", step_ch.u_value, 24'h0);
      end else begin
        head_word = awaited_steps.pop_front();
        if (step_ch.u_value !== head_word.u_value)
          report_mismatch("u_value", step_ch.u_value, head_word.u_value);
        if (step_ch.v_value !== head_word.v_value)
          report_mismatch("v_value", step_ch.v_value, head_word.v_value);
        if (step_ch.u_rate !== head_word.u_rate)
          report_mismatch("u_rate", step_ch.u_rate, head_word.u_rate);
        if (step_ch.v_rate !== head_word.v_rate)
          report_mismatch("v_rate", step_ch.v_rate, head_word.v_rate);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("neural_oscillator_euler_step regression: fail");
      $finish;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_GAIN_UU;
    cfg_data_i      = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.advance = 1'b0;
    step_ch.ready   = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    stall_left      = 0;
    in_gap_pct      = 20;
    ready_gap_pct   = 20;
    ticks_since_cfg = 1'b0;
    u_now  = 0;
    v_now  = 0;
    u_fire = 0;
    v_fire = 0;
    a_uu    = 655360;
    a_uv    = 327680;
    a_vu    = 655360;
    a_vv    = 0;
    drive_u = 0;
    drive_v = -163840;
    tau     = 655;
    mu      = 65536;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (ticks_since_cfg) begin
          settle();
        end
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
        ticks_since_cfg = 1'b0;
      end else begin
        send_tick(directed_rows[i].adv, directed_rows[i].typed, directed_rows[i].want);
        ticks_since_cfg = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      // first phase runs the default oscillator, the rest random settings
      for (int r = 0; r < 8; r++) begin
        if (ph == 0) begin
          case (cfg_reg_e'(r))
            REG_GAIN_UU:   write_reg(REG_GAIN_UU, 24'h0A0000);
            REG_GAIN_UV:   write_reg(REG_GAIN_UV, 24'h050000);
            REG_GAIN_VU:   write_reg(REG_GAIN_VU, 24'h0A0000);
            REG_GAIN_VV:   write_reg(REG_GAIN_VV, 24'h000000);
            REG_BIAS_U:    write_reg(REG_BIAS_U, 24'h000000);
            REG_BIAS_V:    write_reg(REG_BIAS_V, 24'hFD8000);
            REG_STEP_SIZE: write_reg(REG_STEP_SIZE, 24'h00028F);
            default:       write_reg(REG_SLOPE, 24'h010000);
          endcase
        end else begin
          write_reg(cfg_reg_e'(r), pick_reg_value(cfg_reg_e'(r)));
        end
      end
      in_gap_pct    = in_pct_of_phase[ph];
      ready_gap_pct = ready_pct_of_phase[ph];
      steps_sent    = 0;
      while (steps_sent < PHASE_STEPS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'b0, 1'b0, NO_WORD);
        end else begin
          send_tick(1'b1, 1'b0, NO_WORD);
          steps_sent++;
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("neural_oscillator_euler_step regression: pass");
    end else begin
      $display("neural_oscillator_euler_step regression: fail");
    end
    $finish;
  end

endmodule
